// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SPS_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sps assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define SPS_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sps assertion failed");

`endif

// ===== hdl/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants, types and helpers of the spectral peak segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

    // Frame and field geometry
    localparam int FRAME_BINS = 1025;
    localparam int IDX_W      = $clog2(FRAME_BINS + 1);
    localparam int OUT_IDX_W  = 11;
    localparam int SMP_W      = 24;
    localparam int MAG_W      = 25;
    localparam int SUM_W      = 36;
    localparam int THR_W      = 32;
    localparam logic [THR_W-1:0] THR_RESET = 32'd4433324;

    // Classifier arithmetic widths
    localparam int SQ_W   = 2 * SMP_W;          // one 24x24 product
    localparam int HALF_W = SQ_W / 2;           // split of the denominator
    localparam int PP_W   = THR_W + HALF_W;     // one partial product
    localparam int FRAC_W = 16;                 // Q16.16 threshold
    localparam int CMP_W  = THR_W + SQ_W;       // full threshold product

    // Front-to-back queue, depth must be a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CLS_NEITHER,
        CLS_CENTER,
        CLS_ABOVE,
        CLS_BELOW
    } sps_cls_t;

    typedef enum logic {
        SEG_RISING,
        SEG_FALLING
    } sps_seg_t;

    typedef struct packed {
        sps_cls_t           cls;
        logic [MAG_W-1:0]   magnitude;
        logic               last_bin;
    } sps_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sps_qstat_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] center_bin;
        logic [OUT_IDX_W-1:0] left_len;
        logic [OUT_IDX_W-1:0] right_len;
        logic [SUM_W-1:0]     mass_sum;
        logic                 last_mass;
    } sps_mass_t;

    // Difference clamped at zero
    function automatic logic [IDX_W-1:0] sat_sub(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        sat_sub = (a >= b) ? (a - b) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/sps_if.sv =====
// ----------------------------------------------------------------------------
// sps_if
// Streaming channels: spectrum bins in, mass records out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sps_bin_if;
    logic                              valid;
    logic                              ready;
    logic signed [sps_pkg::SMP_W-1:0]  re_now;
    logic signed [sps_pkg::SMP_W-1:0]  im_now;
    logic signed [sps_pkg::SMP_W-1:0]  re_deriv;
    logic signed [sps_pkg::SMP_W-1:0]  im_deriv;
    logic [sps_pkg::MAG_W-1:0]         magnitude;
    logic                              last_bin;

    modport source (output valid, re_now, im_now, re_deriv, im_deriv, magnitude,
                    last_bin, input ready);
    modport sink   (input valid, re_now, im_now, re_deriv, im_deriv, magnitude,
                    last_bin, output ready);
endinterface

interface sps_mass_if;
    logic                            valid;
    logic                            ready;
    logic [sps_pkg::OUT_IDX_W-1:0]   center_bin;
    logic [sps_pkg::OUT_IDX_W-1:0]   left_len;
    logic [sps_pkg::OUT_IDX_W-1:0]   right_len;
    logic [sps_pkg::SUM_W-1:0]       mass_sum;
    logic                            last_mass;

    modport source (output valid, center_bin, left_len, right_len, mass_sum,
                    last_mass, input ready);
    modport sink   (input valid, center_bin, left_len, right_len, mass_sum,
                    last_mass, output ready);
endinterface

`default_nettype wire

// ===== hdl/sps_front.sv =====
// ----------------------------------------------------------------------------
// sps_front
// Four-stage classifier: products, offset terms, threshold partial products,
// and the final compare of |N|*2^16 against T*D.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [sps_pkg::THR_W-1:0]    freq_threshold,
    sps_bin_if.sink                           bin_in,
    output logic                              item_valid,
    input  wire logic                         item_ready,
    output sps_pkg::sps_item_t                item
);

    logic en;

    // stage valids
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg;

    // stage 1: raw products
    logic signed [sps_pkg::SQ_W-1:0] sq_re_reg, sq_im_reg, x1_reg, x2_reg;
    logic signed [sps_pkg::SQ_W-1:0] sq_re_next, sq_im_next, x1_next, x2_next;

    // stage 2: |N|, sign and denominator
    logic [sps_pkg::SQ_W-1:0]        an_reg, an_next;
    logic [sps_pkg::SQ_W-1:0]        deff_reg, deff_next;
    logic                            neg_reg, neg_next;
    logic [sps_pkg::SQ_W-1:0]        d_w;
    logic signed [sps_pkg::SQ_W:0]   n_w;

    // stage 3: threshold partial products
    logic [sps_pkg::PP_W-1:0]        pl_reg, pl_next, ph_reg, ph_next;
    logic [sps_pkg::SQ_W-1:0]        an3_reg;
    logic                            neg3_reg;

    // stage 4: class
    sps_pkg::sps_cls_t               cls_reg, cls_next;
    logic [sps_pkg::CMP_W-1:0]       prod_w, lhs_w;

    // side payload carried along
    logic [sps_pkg::MAG_W-1:0] mag1_reg, mag2_reg, mag3_reg, mag4_reg;
    logic last1_reg, last2_reg, last3_reg, last4_reg;

    // whole pipe moves unless the last stage is blocked by the queue
    assign en           = !s4_v_reg || item_ready;
    assign bin_in.ready = en;

    // stage 1 products
    always_comb
    begin
        sq_re_next = sps_pkg::SQ_W'(bin_in.re_now) * sps_pkg::SQ_W'(bin_in.re_now);
        sq_im_next = sps_pkg::SQ_W'(bin_in.im_now) * sps_pkg::SQ_W'(bin_in.im_now);
        x1_next    = sps_pkg::SQ_W'(bin_in.re_deriv) * sps_pkg::SQ_W'(bin_in.im_now);
        x2_next    = sps_pkg::SQ_W'(bin_in.im_deriv) * sps_pkg::SQ_W'(bin_in.re_now);
    end

    // stage 2: D = |X0|^2, N = Im part; D of zero means offset zero
    always_comb
    begin
        d_w = $unsigned(sq_re_reg) + $unsigned(sq_im_reg);
        n_w = (sps_pkg::SQ_W + 1)'(x1_reg) - (sps_pkg::SQ_W + 1)'(x2_reg);
        if (d_w == '0)
        begin
            deff_next = sps_pkg::SQ_W'(1);
            an_next   = '0;
            neg_next  = 1'b0;
        end
        else
        begin
            deff_next = d_w;
            an_next   = n_w[sps_pkg::SQ_W] ? sps_pkg::SQ_W'(-n_w) : sps_pkg::SQ_W'(n_w);
            neg_next  = n_w[sps_pkg::SQ_W];
        end
    end

    // stage 3: T*D split in two 32x24 products
    always_comb
    begin
        pl_next = sps_pkg::PP_W'(freq_threshold)
                * sps_pkg::PP_W'(deff_reg[sps_pkg::HALF_W-1:0]);
        ph_next = sps_pkg::PP_W'(freq_threshold)
                * sps_pkg::PP_W'(deff_reg[sps_pkg::SQ_W-1:sps_pkg::HALF_W]);
    end

    // stage 4: recombine and compare
    always_comb
    begin
        prod_w = {{(sps_pkg::CMP_W - sps_pkg::PP_W){1'b0}}, pl_reg}
               + {ph_reg, {sps_pkg::HALF_W{1'b0}}};
        lhs_w  = {{(sps_pkg::CMP_W - sps_pkg::SQ_W - sps_pkg::FRAC_W){1'b0}},
                  an3_reg, {sps_pkg::FRAC_W{1'b0}}};
        if (lhs_w < prod_w)
            cls_next = sps_pkg::CLS_CENTER;
        else if (lhs_w > prod_w)
            cls_next = neg3_reg ? sps_pkg::CLS_BELOW : sps_pkg::CLS_ABOVE;
        else
            cls_next = sps_pkg::CLS_NEITHER;
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= bin_in.valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_re_reg <= sq_re_next;
            sq_im_reg <= sq_im_next;
            x1_reg    <= x1_next;
            x2_reg    <= x2_next;
            mag1_reg  <= bin_in.magnitude;
            last1_reg <= bin_in.last_bin;

            an_reg    <= an_next;
            deff_reg  <= deff_next;
            neg_reg   <= neg_next;
            mag2_reg  <= mag1_reg;
            last2_reg <= last1_reg;

            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            an3_reg   <= an_reg;
            neg3_reg  <= neg_reg;
            mag3_reg  <= mag2_reg;
            last3_reg <= last2_reg;

            cls_reg   <= cls_next;
            mag4_reg  <= mag3_reg;
            last4_reg <= last3_reg;
        end
    end

    assign item_valid     = s4_v_reg;
    assign item.cls       = cls_reg;
    assign item.magnitude = mag4_reg;
    assign item.last_bin  = last4_reg;

endmodule

`default_nettype wire

// ===== hdl/sps_queue.sv =====
// ----------------------------------------------------------------------------
// sps_queue
// Small FIFO of classified bins between the classifier and the segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire sps_pkg::sps_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output sps_pkg::sps_item_t       out_item,
    output sps_pkg::sps_qstat_t      stat
);

    sps_pkg::sps_item_t mem [sps_pkg::Q_DEPTH];

    logic [sps_pkg::Q_PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [sps_pkg::Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic push, pop;

    // status
    assign stat.full  = (cnt_reg == sps_pkg::Q_CNT_W'(sps_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign in_ready   = !stat.full;
    assign out_valid  = !stat.empty;
    assign out_item   = mem[rptr_reg];

    // pointer and count update
    always_comb
    begin
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

// ===== hdl/sps_back.sv =====
// ----------------------------------------------------------------------------
// sps_back
// Peak/split tracker: walks the classified bins of a frame, keeps prefix
// sums and emits one record per spectral mass.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire sps_pkg::sps_item_t  item,
    sps_mass_if.source               mass_out
);

    localparam int IW = sps_pkg::IDX_W;
    localparam int MW = sps_pkg::MAG_W;
    localparam int SW = sps_pkg::SUM_W;

    // tracker state
    sps_pkg::sps_seg_t seg_reg, seg_next, seg_upd;
    logic [IW-1:0] bin_count_reg, split_idx_reg, peak_idx_reg, center_reg, start_reg;
    logic [MW-1:0] peak_mag_reg, split_mag_reg;
    logic [SW-1:0] run_reg, tas_reg, tbs_reg;
    logic          prev_above_reg, prev_below_reg;

    // output register plus one spare for a second record on the same bin
    sps_pkg::sps_mass_t out_reg, out_next, hold_reg, hold_next;
    logic out_v_reg, out_v_next, hold_v_reg, hold_v_next;

    // per-bin combinational values
    logic          pop, first, frame_end, cross_up, cross_down;
    logic [IW-1:0] i_plus1, pk_i, sp_i, ctr_w, st_w, fin_c;
    logic [MW-1:0] pk_m, sp_m;
    logic [SW-1:0] run_w, tas_w, tbs_w;
    sps_pkg::sps_mass_t res_a, res_b;

    // a bin is taken only when both record slots are free after this cycle
    assign item_ready = !hold_v_reg && (!out_v_reg || mass_out.ready);
    assign pop        = item_valid && item_ready;

    // events
    always_comb
    begin
        first      = (bin_count_reg == '0);
        frame_end  = item.last_bin || (bin_count_reg >= IW'(sps_pkg::FRAME_BINS - 1));
        cross_up   = !first && (item.cls == sps_pkg::CLS_ABOVE) && !prev_above_reg
                     && (seg_reg == sps_pkg::SEG_FALLING);
        cross_down = !first && (item.cls == sps_pkg::CLS_BELOW) && !prev_below_reg
                     && (seg_reg == sps_pkg::SEG_RISING);
        i_plus1    = bin_count_reg + 1'b1;
    end

    // next state: rising/falling, back to rising at frame end
    always_comb
    begin
        seg_upd = seg_reg;
        if (cross_up)
            seg_upd = sps_pkg::SEG_RISING;
        else if (cross_down)
            seg_upd = sps_pkg::SEG_FALLING;
        seg_next = seg_reg;
        if (pop)
            seg_next = frame_end ? sps_pkg::SEG_RISING : seg_upd;
    end

    // tracker datapath and the records this bin produces
    always_comb
    begin
        run_w = run_reg + SW'(item.magnitude);
        pk_i  = peak_idx_reg;
        pk_m  = peak_mag_reg;
        sp_i  = split_idx_reg;
        sp_m  = split_mag_reg;
        tas_w = tas_reg;
        ctr_w = center_reg;
        st_w  = start_reg;
        tbs_w = tbs_reg;

        if (first)
        begin
            pk_i = '0;
            pk_m = item.magnitude;
        end
        else
        begin
            case (item.cls)
                sps_pkg::CLS_CENTER:
                begin
                    if (seg_reg == sps_pkg::SEG_RISING)
                    begin
                        if (item.magnitude > pk_m)
                        begin
                            pk_i = bin_count_reg;
                            pk_m = item.magnitude;
                        end
                    end
                    else if (item.magnitude < sp_m)
                    begin
                        sp_i  = i_plus1;
                        sp_m  = item.magnitude;
                        tas_w = run_w;
                    end
                end
                sps_pkg::CLS_ABOVE:
                begin
                    if (cross_up)
                    begin
                        st_w  = split_idx_reg;
                        tbs_w = tas_reg;
                        ctr_w = bin_count_reg;
                    end
                    pk_i = bin_count_reg;
                    pk_m = item.magnitude;
                end
                sps_pkg::CLS_BELOW:
                begin
                    if (cross_down)
                    begin
                        if (item.magnitude > pk_m)
                        begin
                            pk_i = bin_count_reg;
                            pk_m = item.magnitude;
                        end
                        ctr_w = pk_i;
                        st_w  = split_idx_reg;
                        tbs_w = tas_reg;
                    end
                    sp_i  = i_plus1;
                    sp_m  = item.magnitude;
                    tas_w = run_w;
                end
                default:
                begin
                end
            endcase
        end

        // mass closed by an upward crossing
        res_a.center_bin = sps_pkg::OUT_IDX_W'(center_reg);
        res_a.left_len   = sps_pkg::OUT_IDX_W'(sps_pkg::sat_sub(center_reg, start_reg));
        res_a.right_len  = sps_pkg::OUT_IDX_W'(sps_pkg::sat_sub(split_idx_reg,
                                                                center_reg + 1'b1));
        res_a.mass_sum   = tas_reg - tbs_reg;
        res_a.last_mass  = 1'b0;

        // final mass of the frame; still rising means the tracked peak is the center
        fin_c            = (seg_upd == sps_pkg::SEG_RISING) ? pk_i : ctr_w;
        res_b.center_bin = sps_pkg::OUT_IDX_W'(fin_c);
        res_b.left_len   = sps_pkg::OUT_IDX_W'(sps_pkg::sat_sub(fin_c, st_w));
        res_b.right_len  = sps_pkg::OUT_IDX_W'(sps_pkg::sat_sub(bin_count_reg, fin_c));
        res_b.mass_sum   = run_w - tbs_w;
        res_b.last_mass  = 1'b1;
    end

    // record slots
    always_comb
    begin
        out_next    = out_reg;
        out_v_next  = out_v_reg;
        hold_next   = hold_reg;
        hold_v_next = hold_v_reg;
        if (out_v_reg && mass_out.ready)
        begin
            out_next    = hold_reg;
            out_v_next  = hold_v_reg;
            hold_v_next = 1'b0;
        end
        if (pop)
        begin
            if (cross_up)
            begin
                out_next   = res_a;
                out_v_next = 1'b1;
                if (frame_end)
                begin
                    hold_next   = res_b;
                    hold_v_next = 1'b1;
                end
            end
            else if (frame_end)
            begin
                out_next   = res_b;
                out_v_next = 1'b1;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg        <= sps_pkg::SEG_RISING;
            bin_count_reg  <= '0;
            prev_above_reg <= 1'b0;
            prev_below_reg <= 1'b0;
            peak_idx_reg   <= '0;
            peak_mag_reg   <= '0;
            split_idx_reg  <= '0;
            split_mag_reg  <= '0;
            center_reg     <= '0;
            start_reg      <= '0;
            run_reg        <= '0;
            tas_reg        <= '0;
            tbs_reg        <= '0;
            out_v_reg      <= 1'b0;
            hold_v_reg     <= 1'b0;
        end
        else
        begin
            seg_reg    <= seg_next;
            out_v_reg  <= out_v_next;
            hold_v_reg <= hold_v_next;
            if (pop)
            begin
                if (frame_end)
                begin
                    bin_count_reg  <= '0;
                    prev_above_reg <= 1'b0;
                    prev_below_reg <= 1'b0;
                    peak_idx_reg   <= '0;
                    peak_mag_reg   <= '0;
                    split_idx_reg  <= '0;
                    split_mag_reg  <= '0;
                    center_reg     <= '0;
                    start_reg      <= '0;
                    run_reg        <= '0;
                    tas_reg        <= '0;
                    tbs_reg        <= '0;
                end
                else
                begin
                    bin_count_reg  <= i_plus1;
                    prev_above_reg <= (item.cls == sps_pkg::CLS_ABOVE);
                    prev_below_reg <= (item.cls == sps_pkg::CLS_BELOW);
                    peak_idx_reg   <= pk_i;
                    peak_mag_reg   <= pk_m;
                    split_idx_reg  <= sp_i;
                    split_mag_reg  <= sp_m;
                    center_reg     <= ctr_w;
                    start_reg      <= st_w;
                    run_reg        <= run_w;
                    tas_reg        <= tas_w;
                    tbs_reg        <= tbs_w;
                end
            end
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign mass_out.valid      = out_v_reg;
    assign mass_out.center_bin = out_reg.center_bin;
    assign mass_out.left_len   = out_reg.left_len;
    assign mass_out.right_len  = out_reg.right_len;
    assign mass_out.mass_sum   = out_reg.mass_sum;
    assign mass_out.last_mass  = out_reg.last_mass;

endmodule

`default_nettype wire

// ===== hdl/spectral_peak_segmenter.sv =====
// ----------------------------------------------------------------------------
// spectral_peak_segmenter
// Classifies spectrum bins by reassigned frequency offset and segments each
// frame into spectral masses (center, extent, summed magnitude).
// ----------------------------------------------------------------------------
//  channel    dir  payload
//  bin_in     in   re_now, im_now, re_deriv, im_deriv, magnitude, last_bin
//  mass_out   out  center_bin, left_len, right_len, mass_sum, last_mass
//  cfg        in   cfg_we / cfg_wdata -> freq_threshold
//
//  One bin per cycle is taken unless stalled; the classifier is a
//  4-stage pipe; the tracker retires one bin per cycle when its slots are free.
//  A bin that closes two masses fills the output register and a spare; the
//  tracker holds its next bin until the spare has moved out.
//  A bin passes the four classifier stages, the queue and the output register.
//  Reset clears all frame state; freq_threshold resets to 4433324.
//  Output stalls back up through the 4-entry queue into the classifier.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module spectral_peak_segmenter (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [sps_pkg::THR_W-1:0]  cfg_wdata,
    sps_bin_if.sink                         bin_in,
    sps_mass_if.source                      mass_out
);

    logic [sps_pkg::THR_W-1:0] thr_reg;

    logic                 fe_valid, q_in_ready, q_out_valid, be_ready;
    sps_pkg::sps_item_t   fe_item, q_item;
    sps_pkg::sps_qstat_t  q_stat;

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= sps_pkg::THR_RESET;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    sps_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .freq_threshold (thr_reg),
        .bin_in         (bin_in),
        .item_valid     (fe_valid),
        .item_ready     (q_in_ready),
        .item           (fe_item)
    );

    sps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (q_in_ready),
        .in_item   (fe_item),
        .out_valid (q_out_valid),
        .out_ready (be_ready),
        .out_item  (q_item),
        .stat      (q_stat)
    );

    sps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_out_valid),
        .item_ready (be_ready),
        .item       (q_item),
        .mass_out   (mass_out)
    );

    // checks
    `SPS_ASSERT_IMP(a_blocked_front_stalls_input, clk, rst_n,
        fe_valid && !q_in_ready, !bin_in.ready)
    `SPS_ASSERT_IMP(a_empty_queue_offers_nothing, clk, rst_n,
        q_stat.empty, !q_out_valid)
    `SPS_ASSERT_NXT(a_full_queue_holds_without_pop, clk, rst_n,
        q_stat.full && !be_ready, q_stat.full)

endmodule

`default_nettype wire
